[hdl/vpc_pkg.sv]
// Shared types, constants and helpers of the voice packet classifier.
package vpc_pkg;

    localparam int unsigned COUNT_LIMIT = 2047;
    localparam int unsigned CNT_W       = $clog2(COUNT_LIMIT + 1);
    localparam int unsigned LEN_W       = 11;
    localparam int unsigned LEN_MAX     = 2047;
    localparam int unsigned WIN_BYTES   = 6;

    localparam logic [7:0] HDR_VER      = 8'hC0;
    localparam logic [7:0] PT_AUDIO     = 8'h03;
    localparam logic [7:0] PT_RTCP      = 8'hC9;
    localparam logic [7:0] TYPE_HI      = 8'hE1;
    localparam logic [7:0] TYPE_SDES    = 8'hCA;
    localparam logic [7:0] TYPE_BYE     = 8'hCB;

    localparam int unsigned AUDIO_LEN   = 144;
    localparam int unsigned RTCP_MIN    = 3;
    localparam int unsigned SDES_MIN    = 10;
    localparam int unsigned BYE_MIN     = 16;
    // last byte of an item starting at offset 16 sits at index 21
    localparam int unsigned ITEM_END    = 21;

    // newest byte in bits 7:0
    localparam logic [8*WIN_BYTES-1:0] PING_ITEM = 48'h050450494E47;
    localparam logic [8*WIN_BYTES-1:0] OPEN_ITEM = 48'h05044F50454E;

    typedef logic [CNT_W-1:0] count_t;
    typedef logic [LEN_W-1:0] len_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } vpc_in_t;

    typedef struct packed {
        logic       is_rtp_audio;
        logic       is_rtcp;
        logic       is_sdes;
        logic       is_bye;
        logic       is_ping;
        logic       is_open;
        len_t       byte_length;
    } vpc_out_t;

    // per-cycle control shared by the header tracker and the window cells
    typedef struct packed {
        logic advance;
        logic clear;
    } vpc_ctl_t;

    typedef struct packed {
        logic ping;
        logic open;
    } vpc_hit_t;

    typedef struct packed {
        count_t      count_next;
        logic [15:0] lead_next;
        logic [15:0] type_next;
        logic        deep;
    } vpc_hdr_t;

    function automatic len_t len_field(input count_t cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return (wide > 32'(LEN_MAX)) ? len_t'(LEN_MAX) : wide[LEN_W-1:0];
    endfunction

endpackage

[hdl/vpc_ifs.sv]
// Request channels of the voice packet classifier: byte input and result output.
interface vpc_in_if;
    logic             valid;
    logic             ready;
    vpc_pkg::vpc_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vpc_out_if;
    logic              valid;
    logic              ready;
    vpc_pkg::vpc_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/vpc_win_cell.sv]
// One byte cell of the sliding match window, with its link of the item compare chain.
module vpc_win_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  vpc_pkg::vpc_ctl_t ctl,
    input  logic [7:0]        byte_in,
    input  logic [7:0]        ping_ref,
    input  logic [7:0]        open_ref,
    input  vpc_pkg::vpc_hit_t hit_in,
    output logic [7:0]        byte_out,
    output vpc_pkg::vpc_hit_t hit_out
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // compare the byte this cell takes on the current shift
    assign hit_out.ping = hit_in.ping && (byte_in == ping_ref);
    assign hit_out.open = hit_in.open && (byte_in == open_ref);

    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.advance)
        begin
            byte_next = ctl.clear ? 8'h00 : byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'h00;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

[hdl/vpc_hdr_track.sv]
// Byte counter and capture of the lead and type byte pairs.
module vpc_hdr_track (
    input  logic              clk,
    input  logic              rst_n,
    input  vpc_pkg::vpc_ctl_t ctl,
    input  logic [7:0]        data_byte,
    output vpc_pkg::vpc_hdr_t hdr
);

    vpc_pkg::count_t count_reg;
    vpc_pkg::count_t count_next;
    vpc_pkg::count_t count_inc;
    logic [15:0]     lead_reg;
    logic [15:0]     lead_upd;
    logic [15:0]     lead_next;
    logic [15:0]     type_reg;
    logic [15:0]     type_upd;
    logic [15:0]     type_next;

    always_comb
    begin
        lead_upd  = lead_reg;
        type_upd  = type_reg;
        count_inc = count_reg;
        if (count_reg == vpc_pkg::count_t'(0)) lead_upd[15:8] = data_byte;
        if (count_reg == vpc_pkg::count_t'(1)) lead_upd[7:0]  = data_byte;
        if (count_reg == vpc_pkg::count_t'(8)) type_upd[15:8] = data_byte;
        if (count_reg == vpc_pkg::count_t'(9)) type_upd[7:0]  = data_byte;
        if (count_reg < vpc_pkg::count_t'(vpc_pkg::COUNT_LIMIT))
        begin
            count_inc = count_reg + vpc_pkg::count_t'(1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        lead_next  = lead_reg;
        type_next  = type_reg;
        if (ctl.advance)
        begin
            count_next = ctl.clear ? '0 : count_inc;
            lead_next  = ctl.clear ? '0 : lead_upd;
            type_next  = ctl.clear ? '0 : type_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            lead_reg  <= '0;
            type_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            lead_reg  <= lead_next;
            type_reg  <= type_next;
        end
    end

    // values as they stand after this byte, before any end-of-packet clear
    assign hdr.count_next = count_inc;
    assign hdr.lead_next  = lead_upd;
    assign hdr.type_next  = type_upd;
    assign hdr.deep       = (count_reg >= vpc_pkg::count_t'(vpc_pkg::ITEM_END));

endmodule

[hdl/voice_packet_classifier_core.sv]
// Top level of the voice packet classifier: window cell row, header tracker, result register.
//
//  port | role | payload                                    | request
//  -----+------+--------------------------------------------+------------------------------
//  rx   | sink | data_byte[7:0], last_byte                  | one byte of a datagram
//  cls  | src  | kind flags, byte_length[10:0]              | one result per final byte
//
// One byte is taken in every cycle while rx.ready is high; the counter update, the six-cell
// window shift and the item compare chain along the cells all settle within that cycle.
// A result is ready in the cycle after its final byte is taken, held in the output register.
// rx.ready drops only while a result sits in the output register and cls.ready is low.
// rst_n clears the counter, captured bytes, window cells, item flags and output valid.
module voice_packet_classifier_core (
    input  logic             clk,
    input  logic             rst_n,
    vpc_in_if.sink           rx,
    vpc_out_if.source        cls
);

    vpc_pkg::vpc_ctl_t ctl;
    vpc_pkg::vpc_hdr_t hdr;
    logic              take;

    logic [7:0]        win_byte [vpc_pkg::WIN_BYTES+1];
    vpc_pkg::vpc_hit_t win_hit  [vpc_pkg::WIN_BYTES+1];

    logic              ping_seen_reg;
    logic              ping_seen_next;
    logic              open_seen_reg;
    logic              open_seen_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    vpc_pkg::vpc_out_t out_data_reg;
    vpc_pkg::vpc_out_t out_data_next;

    logic              rtcp;
    logic              sdes;

    // Accept a byte whenever the output register is free or being emptied.
    assign rx.ready    = !out_valid_reg || cls.ready;
    assign take        = rx.valid && rx.ready;
    assign ctl.advance = take;
    assign ctl.clear   = rx.data.last_byte;

    vpc_hdr_track u_hdr (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .data_byte (rx.data.data_byte),
        .hdr       (hdr)
    );

    // Row of window cells: cell 0 holds the newest byte.
    assign win_byte[0]     = rx.data.data_byte;
    assign win_hit[0].ping = 1'b1;
    assign win_hit[0].open = 1'b1;

    for (genvar i = 0; i < vpc_pkg::WIN_BYTES; i++)
    begin : g_cell
        vpc_win_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .byte_in  (win_byte[i]),
            .ping_ref (vpc_pkg::PING_ITEM[8*i +: 8]),
            .open_ref (vpc_pkg::OPEN_ITEM[8*i +: 8]),
            .hit_in   (win_hit[i]),
            .byte_out (win_byte[i+1]),
            .hit_out  (win_hit[i+1])
        );
    end

    // Remember an item hit only once the item may have started at offset 16
    // and only on a byte that is not the final one; drop it at packet end.
    always_comb
    begin
        ping_seen_next = ping_seen_reg;
        open_seen_next = open_seen_reg;
        if (take)
        begin
            if (rx.data.last_byte)
            begin
                ping_seen_next = 1'b0;
                open_seen_next = 1'b0;
            end
            else if (hdr.deep)
            begin
                ping_seen_next = ping_seen_reg || win_hit[vpc_pkg::WIN_BYTES].ping;
                open_seen_next = open_seen_reg || win_hit[vpc_pkg::WIN_BYTES].open;
            end
        end
    end

    // Classify from the state as it stands after the final byte.
    assign rtcp = (hdr.count_next >= vpc_pkg::count_t'(vpc_pkg::RTCP_MIN))
               && (hdr.lead_next == {vpc_pkg::HDR_VER, vpc_pkg::PT_RTCP});
    assign sdes = rtcp
               && (hdr.count_next >= vpc_pkg::count_t'(vpc_pkg::SDES_MIN))
               && (hdr.type_next == {vpc_pkg::TYPE_HI, vpc_pkg::TYPE_SDES});

    always_comb
    begin
        out_data_next.is_rtp_audio =
            (hdr.count_next == vpc_pkg::count_t'(vpc_pkg::AUDIO_LEN))
            && (hdr.lead_next == {vpc_pkg::HDR_VER, vpc_pkg::PT_AUDIO});
        out_data_next.is_rtcp      = rtcp;
        out_data_next.is_sdes      = sdes;
        out_data_next.is_bye       = rtcp
            && (hdr.count_next >= vpc_pkg::count_t'(vpc_pkg::BYE_MIN))
            && (hdr.type_next == {vpc_pkg::TYPE_HI, vpc_pkg::TYPE_BYE});
        out_data_next.is_ping      = sdes && ping_seen_reg;
        out_data_next.is_open      = sdes && open_seen_reg;
        out_data_next.byte_length  = vpc_pkg::len_field(hdr.count_next);
    end

    // Load the result on a final byte, otherwise empty when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take && rx.data.last_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (cls.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ping_seen_reg <= 1'b0;
            open_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ping_seen_reg <= ping_seen_next;
            open_seen_reg <= open_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && rx.data.last_byte)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign cls.valid = out_valid_reg;
    assign cls.data  = out_data_reg;

`ifndef SYNTHESIS
    a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        (take && rx.data.last_byte) |=> out_valid_reg)
        else $error("no result after final byte");

    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (take && rx.data.last_byte) |=> (hdr.count_next == vpc_pkg::count_t'(1)))
        else $error("byte count not cleared at packet end");

    a_item_needs_sdes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((!out_data_reg.is_ping && !out_data_reg.is_open)
                           || out_data_reg.is_sdes))
        else $error("item flag without SDES");

    a_sdes_bye_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.is_sdes && out_data_reg.is_bye))
        else $error("SDES and BYE both flagged");

    a_seen_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (take && rx.data.last_byte) |=> (!ping_seen_reg && !open_seen_reg))
        else $error("item flags survive packet end");
`endif

endmodule

[tb/tb_voice_packet_classifier_core.sv]
// Self-checking testbench of the voice packet classifier core, driven one byte per request.
module tb_voice_packet_classifier_core;
    import vpc_pkg::*;

    // Generous ceiling: just over 2000 bytes, each possibly behind an input gap,
    // plus result stalls and the drain pauses, taken several times over.
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef enum {PK_AUDIO, PK_SDES, PK_BYE, PK_MIXED} pkt_kind_e;

    // Tracks the per-packet state of the classifier, predicts the verdict on each
    // final byte and checks the verdicts that the block hands out, oldest first.
    class classifier_tracker;
        count_t                 seen_len;
        logic [15:0]            lead_pair;
        logic [15:0]            type_pair;
        logic [8*WIN_BYTES-1:0] item_window;
        bit                     ping_hit;
        bit                     open_hit;
        vpc_out_t               verdicts_due[$];
        int unsigned            mismatches;

        function new();
            start_packet();
            mismatches = 0;
        endfunction

        function void start_packet();
            seen_len    = '0;
            lead_pair   = '0;
            type_pair   = '0;
            item_window = '0;
            ping_hit    = 1'b0;
            open_hit    = 1'b0;
        endfunction

        function void take_byte(vpc_in_t req);
            int unsigned idx;
            int unsigned len;
            bit          rtcp;
            bit          sdes;
            vpc_out_t    verdict;
            idx = seen_len;
            case (idx)
                0: lead_pair[15:8] = req.data_byte;
                1: lead_pair[7:0]  = req.data_byte;
                8: type_pair[15:8] = req.data_byte;
                9: type_pair[7:0]  = req.data_byte;
                default: ;
            endcase
            item_window = {item_window[8*WIN_BYTES-9:0], req.data_byte};
            if (seen_len < COUNT_LIMIT)
            begin
                seen_len = seen_len + 1'b1;
            end
            if (!req.last_byte)
            begin
                // an item only counts if it starts at offset 16 or later
                // and is complete before the final byte
                if (idx >= ITEM_END)
                begin
                    if (item_window == PING_ITEM) ping_hit = 1'b1;
                    if (item_window == OPEN_ITEM) open_hit = 1'b1;
                end
                return;
            end
            len  = seen_len;
            rtcp = (len >= RTCP_MIN) && (lead_pair == {HDR_VER, PT_RTCP});
            sdes = rtcp && (len >= SDES_MIN) && (type_pair == {TYPE_HI, TYPE_SDES});
            verdict.is_rtp_audio = (len == AUDIO_LEN) && (lead_pair == {HDR_VER, PT_AUDIO});
            verdict.is_rtcp      = rtcp;
            verdict.is_sdes      = sdes;
            verdict.is_bye       = rtcp && (len >= BYE_MIN)
                                   && (type_pair == {TYPE_HI, TYPE_BYE});
            verdict.is_ping      = sdes && ping_hit;
            verdict.is_open      = sdes && open_hit;
            verdict.byte_length  = (len > LEN_MAX) ? len_t'(LEN_MAX) : len_t'(len);
            verdicts_due.push_back(verdict);
            start_packet();
        endfunction

        function void field_ok(string name, logic [LEN_W-1:0] want, logic [LEN_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_verdict(vpc_out_t got);
            vpc_out_t want;
            if (verdicts_due.size() == 0)
            begin
                $error("result with no final byte behind it: %h", got);
                mismatches++;
                return;
            end
            want = verdicts_due.pop_front();
            field_ok("is_rtp_audio", want.is_rtp_audio, got.is_rtp_audio);
            field_ok("is_rtcp", want.is_rtcp, got.is_rtcp);
            field_ok("is_sdes", want.is_sdes, got.is_sdes);
            field_ok("is_bye", want.is_bye, got.is_bye);
            field_ok("is_ping", want.is_ping, got.is_ping);
            field_ok("is_open", want.is_open, got.is_open);
            field_ok("byte_length", want.byte_length, got.byte_length);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    vpc_in_if  rx();
    vpc_out_if cls();

    voice_packet_classifier_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .cls   (cls)
    );

    classifier_tracker tracker;
    logic [7:0]        pkt[$];
    bit                quiet;
    int unsigned       gap_odds;
    int unsigned       stall_odds;
    int unsigned       cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Sample both handshakes at the rising edge; the tracker keeps the expected
    // verdicts in order, so a byte and a result on the same edge do not clash.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx.valid && rx.ready)
            begin
                tracker.take_byte(rx.data);
            end
            if (cls.valid && cls.ready)
            begin
                tracker.check_verdict(cls.data);
            end
        end
    end

    // Abandon the run if it hangs.
    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: hold ready low in random bursts, at a rate that the sender
    // changes per packet; drop the stalls altogether in the quiet tail.
    initial
    begin
        cls.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0)
            begin
                cls.ready = 1'b0;
                repeat ($urandom_range(17, 1)) @(negedge clk);
            end
            cls.ready = 1'b1;
        end
    end

    function automatic int unsigned pick_odds();
        case ($urandom_range(2, 0))
            0:       return 0;
            1:       return 3;
            default: return 12;
        endcase
    endfunction

    // Offer one byte from a falling edge and hold it until it is taken; return at
    // the falling edge after acceptance so the next request follows back to back.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!quiet && gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0)
        begin
            rx.valid = 1'b0;
            repeat ($urandom_range(17, 1)) @(negedge clk);
        end
        rx.valid = 1'b1;
        rx.data  = '{data_byte: b, last_byte: last};
        do @(posedge clk); while (!rx.ready);
        @(negedge clk);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++)
        begin
            send_byte(pkt[i], i == pkt.size() - 1);
        end
    endtask

    // Hold the input idle until every verdict owed has come out.
    task automatic drain_results();
        rx.valid = 1'b0;
        while (tracker.verdicts_due.size() != 0) @(negedge clk);
    endtask

    function automatic void fill_random(int unsigned len);
        pkt.delete();
        repeat (len) pkt.push_back(8'($urandom_range(255, 0)));
    endfunction

    // Overwrite a byte, but only where the packet reaches.
    function automatic void put(int unsigned pos, logic [7:0] b);
        if (pos < pkt.size())
        begin
            pkt[pos] = b;
        end
    endfunction

    function automatic void put_item(int unsigned start, logic [8*WIN_BYTES-1:0] item);
        for (int k = 0; k < WIN_BYTES; k++)
        begin
            put(start + k, item[8*WIN_BYTES-1-8*k -: 8]);
        end
    endfunction

    // Build one packet: mostly well-formed headers with random bodies, with items
    // dropped near the edges of the allowed window, and a share of broken ones.
    task automatic random_packet();
        pkt_kind_e              kind;
        int unsigned            len;
        logic [8*WIN_BYTES-1:0] item;
        kind = pkt_kind_e'($urandom_range(3, 0));
        case (kind)
            PK_AUDIO:
            begin
                len = ($urandom_range(3, 0) == 0) ? $urandom_range(145, 143) : AUDIO_LEN;
                fill_random(len);
                put(0, HDR_VER);
                put(1, PT_AUDIO);
            end
            PK_SDES:
            begin
                fill_random($urandom_range(48, 10));
                put(0, HDR_VER);
                put(1, PT_RTCP);
                put(8, TYPE_HI);
                put(9, TYPE_SDES);
            end
            PK_BYE:
            begin
                fill_random($urandom_range(40, 14));
                put(0, HDR_VER);
                put(1, PT_RTCP);
                put(8, TYPE_HI);
                put(9, TYPE_BYE);
            end
            default:
            begin
                // near misses of the lead bytes and of the high type byte, and plain noise
                fill_random($urandom_range(40, 1));
                case ($urandom_range(3, 0))
                    0: begin put(0, HDR_VER); put(1, PT_RTCP); end
                    1: begin put(0, HDR_VER); put(1, PT_RTCP ^ 8'h01); end
                    2: begin put(0, HDR_VER ^ 8'h01); put(1, PT_RTCP); end
                    default: ;
                endcase
                case ($urandom_range(3, 0))
                    0: begin put(8, TYPE_HI); put(9, TYPE_SDES); end
                    1: begin put(8, TYPE_HI); put(9, TYPE_BYE); end
                    2: begin put(8, TYPE_HI ^ 8'h01); put(9, TYPE_SDES); end
                    default: ;
                endcase
            end
        endcase
        // Place up to two items; a start of 14 or 15, or an item ending on the
        // final byte, must not count.
        repeat (2)
        begin
            if (pkt.size() >= 20 && $urandom_range(2, 0) != 0)
            begin
                item = $urandom_range(1, 0) ? PING_ITEM : OPEN_ITEM;
                if ($urandom_range(5, 0) == 0)
                begin
                    item[8*$urandom_range(WIN_BYTES - 1, 0) +: 8] ^= 8'h10;
                end
                put_item($urandom_range(pkt.size() - WIN_BYTES, 14), item);
            end
        end
        // break a header byte now and then
        if ($urandom_range(9, 0) == 0)
        begin
            put($urandom_range(9, 0), 8'($urandom_range(255, 0)));
        end
    endtask

    initial
    begin
        int unsigned short_bytes;
        tracker    = new();
        quiet      = 1'b0;
        gap_odds   = 0;
        stall_odds = 0;
        rx.valid   = 1'b0;
        rx.data    = '0;
        rst_n      = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: one-byte packets at both byte extremes, RTCP header on a
        // two-byte packet (too short) and a three-byte one, and the shortest SDES.
        pkt = '{8'hFF};
        send_packet();
        pkt = '{8'h00};
        send_packet();
        pkt = '{HDR_VER, PT_RTCP};
        send_packet();
        pkt = '{HDR_VER, PT_RTCP, 8'h00};
        send_packet();
        pkt = '{HDR_VER, PT_RTCP, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80,
                TYPE_HI, TYPE_SDES};
        send_packet();
        drain_results();

        // Random: short packets up to about 2000 bytes in all.
        short_bytes = 0;
        while (short_bytes < 2000)
        begin
            random_packet();
            short_bytes += pkt.size();
            quiet      = (short_bytes >= 1700);
            gap_odds   = pick_odds();
            stall_odds = pick_odds();
            send_packet();
            if ($urandom_range(24, 0) == 0)
            begin
                drain_results();
            end
        end
        rx.valid = 1'b0;

        while (tracker.verdicts_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/vpc_pkg.sv
hdl/vpc_ifs.sv
hdl/vpc_win_cell.sv
hdl/vpc_hdr_track.sv
hdl/voice_packet_classifier_core.sv
tb/tb_voice_packet_classifier_core.sv
